[hw/rtl/i2cbl_pkg.sv]
// Shared constants, command codes and step helpers for the I2C bit-level master.
`timescale 1ns / 1ps
package i2cbl_pkg;

  localparam int unsigned HOLD_COUNT_BITS = 16;
  localparam int unsigned HOLD_TICKS_BITS = 16;
  localparam logic [HOLD_TICKS_BITS-1:0] HOLD_TICKS_RESET = 16'd10;
  localparam logic [31:0] HOLD_MAX = 32'((64'd1 << HOLD_COUNT_BITS) - 64'd1);

  localparam logic [2:0] CMD_IDLE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_SACK  = 3'd5;
  localparam logic [2:0] CMD_RACK  = 3'd6;

  typedef struct packed {
    logic [2:0] bit_idx;
    logic [1:0] phase;
  } step_pos_t;

  function automatic logic [4:0] seq_length(input logic [2:0] cmd);
    logic [4:0] len;
    unique case (cmd)
      CMD_START: len = 5'd4;
      CMD_STOP:  len = 5'd3;
      CMD_WRITE: len = 5'd24;
      CMD_READ:  len = 5'd25;
      CMD_SACK:  len = 5'd3;
      CMD_RACK:  len = 5'd4;
      default:   len = 5'd0;
    endcase
    return len;
  endfunction

  // Splits a step number into the bit it belongs to and its phase within that bit.
  function automatic step_pos_t step_pos(input logic [4:0] idx);
    step_pos_t  pos;
    logic [4:0] base;
    pos.bit_idx = 3'd0;
    base        = 5'd0;
    for (int k = 1; k < 8; k++) begin
      if (idx >= 5'(3 * k)) begin
        pos.bit_idx = 3'(k);
        base        = 5'(3 * k);
      end
    end
    pos.phase = 2'(idx - base);
    return pos;
  endfunction

endpackage

[hw/rtl/i2cbl_cmd_if.sv]
// Tick channel: command, transmit byte, ack bit and sampled SDA level.
`timescale 1ns / 1ps
interface i2cbl_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] tx_data;
  logic       ack_out;
  logic       sda_in;

  modport source (output valid, kind, tx_data, ack_out, sda_in, input ready);
  modport sink (input valid, kind, tx_data, ack_out, sda_in, output ready);
endinterface

[hw/rtl/i2cbl_res_if.sv]
// Result channel: pin drives and status for one tick.
`timescale 1ns / 1ps
interface i2cbl_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_data;
  logic       rx_ack;
  logic       rejected;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_data, rx_ack,
                  rejected, input ready);
  modport sink (input valid, scl_level, sda_level, busy_res, done_res, rx_data, rx_ack,
                rejected, output ready);
endinterface

[hw/rtl/i2cbl_cfg_if.sv]
// Configuration write channel carrying the hold length in ticks.
`timescale 1ns / 1ps
interface i2cbl_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[hw/rtl/i2c_bit_level_master.sv]
// Top level of the I2C bit-level master sequencer.
//
// Usage: every word on cmd_i is one time tick. It carries a command kind (start, stop,
// write byte, read byte, send ack, read ack, or none), the byte and ack bit for the
// command, and the SDA level sampled on that tick. A command is taken only while the
// sequencer is idle; one that arrives while busy is dropped and flagged as rejected.
// Each accepted tick yields exactly one word on res_o with the SCL and SDA drives,
// busy, done, the received byte and the received ack bit.
// Each pin step of a command is held for hold_ticks ticks (zero acts as one), set via cfg_i.
// A tick's result word is valid in the next cycle; unless res_o stalls, a tick can be
// accepted in every cycle: all the work is one pass of logic into the result register.
// The output register sits between the channels; while the receiver stalls, the held
// word is kept and a new tick is accepted in the same cycle the held word is taken.
// Reset leaves the sequencer idle with both lines released high, hold_ticks at ten,
// and the received byte and ack cleared. cfg_i is always ready.
`timescale 1ns / 1ps
module i2c_bit_level_master (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2cbl_cmd_if.sink         cmd_i,
  i2cbl_cfg_if.sink         cfg_i,
  i2cbl_res_if.source       res_o
);

  logic [2:0]                             cmd_q, cmd_d;
  logic [4:0]                             step_q, step_d;
  logic [i2cbl_pkg::HOLD_COUNT_BITS-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [7:0]                             tx_q, tx_d;
  logic [7:0]                             rx_q, rx_d;
  logic                                   scl_q, scl_d;
  logic                                   sda_q, sda_d;
  logic                                   ack_q, ack_d;
  logic [i2cbl_pkg::HOLD_TICKS_BITS-1:0]  hold_ticks_q;
  logic [31:0]                            hold_eff;
  logic [4:0]                             step_inc;
  i2cbl_pkg::step_pos_t                   pos_w, pos_r;
  logic                                   in_acc, kind_cmd;
  logic                                   busy, done, rej;
  logic                                   res_valid_q;

  assign in_acc      = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign cfg_i.ready = 1'b1;
  assign kind_cmd    = (cmd_i.kind >= i2cbl_pkg::CMD_START) &&
                       (cmd_i.kind <= i2cbl_pkg::CMD_RACK);

  always_comb begin
    if (hold_ticks_q == '0) begin
      hold_eff = 32'd1;
    end else if (32'(hold_ticks_q) > i2cbl_pkg::HOLD_MAX) begin
      hold_eff = i2cbl_pkg::HOLD_MAX;
    end else begin
      hold_eff = 32'(hold_ticks_q);
    end
  end

  always_comb begin
    cmd_d    = cmd_q;
    step_d   = step_q;
    cnt_d    = cnt_q;
    tx_d     = tx_q;
    rx_d     = rx_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    ack_d    = ack_q;
    busy     = 1'b0;
    done     = 1'b0;
    rej      = 1'b0;
    cnt_inc  = '0;
    step_inc = '0;
    pos_w    = i2cbl_pkg::step_pos(step_q);
    pos_r    = i2cbl_pkg::step_pos(step_q - 5'd1);

    if (cmd_q == i2cbl_pkg::CMD_IDLE) begin
      if (kind_cmd) begin
        cmd_d  = cmd_i.kind;
        step_d = '0;
        cnt_d  = '0;
        if (cmd_i.kind == i2cbl_pkg::CMD_WRITE) begin
          tx_d = cmd_i.tx_data;
        end else if (cmd_i.kind == i2cbl_pkg::CMD_SACK) begin
          tx_d = {cmd_i.ack_out, 7'd0};
        end
        if (cmd_i.kind == i2cbl_pkg::CMD_READ) begin
          rx_d = '0;
        end
      end
    end else if (kind_cmd) begin
      rej = 1'b1;
    end

    if (cmd_d != i2cbl_pkg::CMD_IDLE) begin
      busy  = 1'b1;
      pos_w = i2cbl_pkg::step_pos(step_d);
      pos_r = i2cbl_pkg::step_pos(step_d - 5'd1);
      if (cnt_d == '0) begin
        unique case (cmd_d)
          i2cbl_pkg::CMD_START: begin
            unique case (step_d)
              5'd0:    sda_d = 1'b1;
              5'd1:    scl_d = 1'b1;
              5'd2:    sda_d = 1'b0;
              default: scl_d = 1'b0;
            endcase
          end
          i2cbl_pkg::CMD_STOP: begin
            unique case (step_d)
              5'd0:    sda_d = 1'b0;
              5'd1:    scl_d = 1'b1;
              default: sda_d = 1'b1;
            endcase
          end
          i2cbl_pkg::CMD_WRITE: begin
            unique case (pos_w.phase)
              2'd0:    sda_d = tx_d[3'd7 - pos_w.bit_idx];
              2'd1:    scl_d = 1'b1;
              default: scl_d = 1'b0;
            endcase
          end
          i2cbl_pkg::CMD_READ: begin
            if (step_d == 5'd0) begin
              sda_d = 1'b1;
            end else begin
              unique case (pos_r.phase)
                2'd0: scl_d = 1'b1;
                2'd1: begin
                  if (cmd_i.sda_in) begin
                    rx_d[3'd7 - pos_r.bit_idx] = 1'b1;
                  end
                end
                default: scl_d = 1'b0;
              endcase
            end
          end
          i2cbl_pkg::CMD_SACK: begin
            unique case (step_d)
              5'd0:    sda_d = tx_d[7];
              5'd1:    scl_d = 1'b1;
              default: scl_d = 1'b0;
            endcase
          end
          i2cbl_pkg::CMD_RACK: begin
            unique case (step_d)
              5'd0:    sda_d = 1'b1;
              5'd1:    scl_d = 1'b1;
              5'd2:    ack_d = cmd_i.sda_in;
              default: scl_d = 1'b0;
            endcase
          end
          default: begin
          end
        endcase
      end
      cnt_inc = cnt_d + 1'b1;
      if ((32'(cnt_inc) >= hold_eff) || (cnt_inc == '0)) begin
        cnt_d    = '0;
        step_inc = step_d + 5'd1;
        if (step_inc >= i2cbl_pkg::seq_length(cmd_d)) begin
          done   = 1'b1;
          cmd_d  = i2cbl_pkg::CMD_IDLE;
          step_d = '0;
        end else begin
          step_d = step_inc;
        end
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q  <= i2cbl_pkg::CMD_IDLE;
      step_q <= '0;
      cnt_q  <= '0;
      tx_q   <= '0;
      rx_q   <= '0;
      scl_q  <= 1'b1;
      sda_q  <= 1'b1;
      ack_q  <= 1'b0;
    end else if (in_acc) begin
      cmd_q  <= cmd_d;
      step_q <= step_d;
      cnt_q  <= cnt_d;
      tx_q   <= tx_d;
      rx_q   <= rx_d;
      scl_q  <= scl_d;
      sda_q  <= sda_d;
      ack_q  <= ack_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= i2cbl_pkg::HOLD_TICKS_RESET;
    end else if (cfg_i.valid) begin
      hold_ticks_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_acc) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_o.scl_level <= scl_d;
      res_o.sda_level <= sda_d;
      res_o.busy_res  <= busy;
      res_o.done_res  <= done;
      res_o.rx_data   <= rx_d;
      res_o.rx_ack    <= ack_d;
      res_o.rejected  <= rej;
    end
  end

  assign res_o.valid = res_valid_q;

endmodule

[hw/rtl/i2cbl_checker.sv]
// Port-level checks for the I2C bit-level master, bound to the top level.
`timescale 1ns / 1ps
module i2cbl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cmd_valid_i,
  input logic       cmd_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       busy_i,
  input logic       done_i,
  input logic       rejected_i,
  input logic [7:0] rx_data_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && done_i) |-> busy_i)
    else $error("done reported on a tick that was not busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && rejected_i) |-> busy_i)
    else $error("command rejected while the sequencer was idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> cmd_ready_i)
    else $error("tick refused although the result register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_i) |=> res_valid_i)
    else $error("accepted tick produced no result word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(rx_data_i) && $stable(busy_i)))
    else $error("stalled result word changed");

endmodule

bind i2c_bit_level_master i2cbl_checker u_i2cbl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .busy_i      (res_o.busy_res),
  .done_i      (res_o.done_res),
  .rejected_i  (res_o.rejected),
  .rx_data_i   (res_o.rx_data)
);
